>>> hdl/hashed_key_lru_cache_macros.svh
// Assertion macros shared by the hashed key LRU cache RTL.
// No dependencies; included by the top level for its concurrent checks.
`ifndef HASHED_KEY_LRU_CACHE_MACROS_SVH
`define HASHED_KEY_LRU_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HKLC_ASSERT_IMPL(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HKLC_ASSERT_NEXT(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hklc_pkg.sv
// Shared types and constants of the hashed key LRU cache.
// No dependencies; imported by the front, queue, back end and top level.
`default_nettype none

package hklc_pkg;

	localparam int KEY_W  = 64;
	localparam int BYTE_W = 8;
	localparam int AGE_W  = 32;
	localparam int SLOT_W = 6;
	localparam int CMD_W  = 2;
	localparam int IN_DATA_W  = BYTE_W + KEY_W;
	localparam int OUT_DATA_W = 1 + SLOT_W + KEY_W + 1;

	// FNV-1a 64: prime is 2^40 + 0x1b3, so multiply as shift plus narrow product
	localparam logic [KEY_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam int               FNV_SHIFT = 40;
	localparam logic [8:0]       FNV_LOW   = 9'h1b3;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE   = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] key;
	} op_t;

endpackage

`default_nettype wire

>>> hdl/hklc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the key and age store of the cache.
`default_nettype none

module hklc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/hklc_fifo.sv
// Short command queue that decouples the hashing front from the cache back.
// Depends on hklc_pkg for the queued operation type and queue depth.
`default_nettype none

module hklc_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hklc_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output hklc_pkg::op_t      head
);

	import hklc_pkg::*;

	op_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed operations
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/hklc_front.sv
// Input front: takes stream beats, runs the FNV-1a hash and queues cache operations.
// Depends on hklc_pkg for commands, hash constants and the operation type.
`default_nettype none

module hklc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [hklc_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic [hklc_pkg::CMD_W-1:0]     s_tuser,
	input  wire logic                           s_tlast,
	input  wire logic                           q_full,
	output logic                                push,
	output hklc_pkg::op_t                       push_op
);

	import hklc_pkg::*;

	logic [KEY_W-1:0] hash_q;
	logic [KEY_W-1:0] mix;
	logic [KEY_W-1:0] hash_nxt;
	logic             take;

	// Every accepted beat fits: at most one queue entry per beat
	assign s_tready = !q_full;
	assign take     = s_tvalid && !q_full;

	// One FNV-1a round: xor the byte, multiply by 2^40 + 0x1b3
	assign mix      = hash_q ^ KEY_W'(s_tdata[BYTE_W-1:0]);
	assign hash_nxt = (mix << FNV_SHIFT) + KEY_W'(mix * FNV_LOW);

	// Classify the beat into a queued operation
	always_comb begin
		push         = 1'b0;
		push_op.kind = KIND_INSERT;
		push_op.key  = hash_nxt;
		unique case (s_tuser)
			CMD_BYTE: begin
				push = take && s_tlast;
			end
			CMD_LOOKUP: begin
				push         = take;
				push_op.kind = KIND_LOOKUP;
				push_op.key  = s_tdata[IN_DATA_W-1:BYTE_W];
			end
			CMD_CLEAR: begin
				push         = take;
				push_op.kind = KIND_CLEAR;
				push_op.key  = '0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Hold the running hash; restart it after the last byte of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (take && (s_tuser == CMD_BYTE)) begin
			hash_q <= s_tlast ? FNV_BASIS : hash_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/hklc_back.sv
// Cache back end: scans the key/age store, picks hit or victim, writes back, holds the result.
// Depends on hklc_pkg and hklc_ram.
`default_nettype none

module hklc_back #(
	parameter int ENTRIES = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_empty,
	input  wire hklc_pkg::op_t                   q_head,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [hklc_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser
);

	import hklc_pkg::*;

	localparam int IW    = $clog2(ENTRIES);
	localparam int CW    = IW + 1;
	localparam int ENT_W = AGE_W + KEY_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [CW-1:0]     fill_q;
	logic [AGE_W-1:0]  clock_q;
	logic [CW-1:0]     idx_q;
	logic              chk_vld_q;
	logic [IW-1:0]     chk_idx_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic              min_vld_q;
	logic [AGE_W-1:0]  min_age_q;
	logic [IW-1:0]     min_idx_q;

	logic              out_vld_q;
	kind_t             out_kind_q;
	logic              out_found_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_repl_q;

	logic [ENT_W-1:0]  rd_data;
	logic [KEY_W-1:0]  rd_key;
	logic [AGE_W-1:0]  rd_age;
	logic              issue;
	logic              match;
	logic              full;
	logic [AGE_W-1:0]  tick;
	logic [IW-1:0]     victim;
	logic              we;
	logic              is_insert;

	// Valid entries always form the prefix below the fill count
	assign full      = (fill_q == CW'(ENTRIES));
	assign tick      = clock_q + 1'b1;
	assign rd_key    = rd_data[KEY_W-1:0];
	assign rd_age    = rd_data[ENT_W-1:KEY_W];
	assign issue     = (state_q == ST_SCAN) && (idx_q < fill_q);
	assign match     = chk_vld_q && (rd_key == op_q.key);
	assign is_insert = (op_q.kind == KIND_INSERT);
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && (!out_vld_q || m_tready);

	// Target slot: hit entry, else first free slot, else least recently used
	assign victim = hit_q ? hit_idx_q : (full ? min_idx_q : fill_q[IW-1:0]);
	assign we     = (state_q == ST_DONE) && (hit_q || is_insert);

	hklc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (victim),
		.wdata ({tick, op_q.key}),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_kind_q;
	// m_tdata from bit 0 up: found, slot, key_out, replaced
	assign m_tdata  = {out_repl_q, out_key_q, out_slot_q, out_found_q};

	// Sequencer: pop, scan the store one entry per cycle, then commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '{kind: KIND_LOOKUP, key: '0};
			fill_q      <= '0;
			clock_q     <= '0;
			idx_q       <= '0;
			chk_vld_q   <= 1'b0;
			chk_idx_q   <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			min_vld_q   <= 1'b0;
			min_age_q   <= '0;
			min_idx_q   <= '0;
			out_vld_q   <= 1'b0;
			out_kind_q  <= KIND_LOOKUP;
			out_found_q <= 1'b0;
			out_slot_q  <= '0;
			out_key_q   <= '0;
			out_repl_q  <= 1'b0;
		end else begin
			// Drop the result once the beat is taken
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.kind == KIND_CLEAR) begin
							fill_q      <= '0;
							clock_q     <= '0;
							out_vld_q   <= 1'b1;
							out_kind_q  <= KIND_CLEAR;
							out_found_q <= 1'b0;
							out_slot_q  <= '0;
							out_key_q   <= '0;
							out_repl_q  <= 1'b0;
						end else begin
							op_q      <= q_head;
							idx_q     <= '0;
							chk_vld_q <= 1'b0;
							hit_q     <= 1'b0;
							min_vld_q <= 1'b0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					chk_vld_q <= issue;
					chk_idx_q <= idx_q[IW-1:0];
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= chk_idx_q;
						state_q   <= ST_DONE;
					end else begin
						// Track the oldest entry; strict compare keeps the lowest index
						if (chk_vld_q && (!min_vld_q || (rd_age < min_age_q))) begin
							min_vld_q <= 1'b1;
							min_age_q <= rd_age;
							min_idx_q <= chk_idx_q;
						end
						if (!issue && !chk_vld_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (we) begin
						clock_q <= tick;
					end
					if (!hit_q && is_insert && !full) begin
						fill_q <= fill_q + 1'b1;
					end
					out_vld_q   <= 1'b1;
					out_kind_q  <= op_q.kind;
					out_found_q <= hit_q;
					out_slot_q  <= we ? SLOT_W'(victim) : '0;
					out_key_q   <= op_q.key;
					out_repl_q  <= !hit_q && is_insert && full;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/hashed_key_lru_cache.sv
// Top level of the hashed key LRU cache: front, command queue and back end.
// Depends on hklc_pkg, hklc_front, hklc_fifo, hklc_back and the assertion macros.
//
// Usage:
//   Input beats on s_t*: s_tuser is the command (hash byte, lookup key, clear),
//   s_tdata carries data_byte in [7:0] and lookup_key in [71:8], s_tlast marks
//   the final byte of a hashed stream. Byte beats are taken one per cycle while
//   the queue is not full; only the last byte, a lookup or a clear produces a
//   result beat on m_t*. Result beats: m_tuser is the result kind, m_tdata
//   holds found, slot, key_out and replaced from bit 0 up.
//   A clear is answered straight from the queue; a lookup or insert scans the
//   valid entries one per cycle through the key/age RAM's single read port;
//   a hit at slot n ends the scan there, and an empty cache is not scanned.
//   Operations run one at a time, the next popped as the previous result beat
//   is taken, so the back end takes no new operation before the last is done.
//   A two-entry queue lets the front keep hashing bytes while the back scans;
//   s_tready drops only when that queue is full.
//   Reset empties the cache, zeroes the use clock and restarts the hash; no
//   clearing pass is needed. When m_tready is low the result beat is held and
//   the back end waits before starting the next operation.
`default_nettype none

`include "hashed_key_lru_cache_macros.svh"

module hashed_key_lru_cache #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_byte, lookup_key
	input  wire logic [1:0]  s_tuser,   // command
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // found, slot, key_out, replaced
	output logic [1:0]       m_tuser    // result_kind
);

	import hklc_pkg::*;

	logic push;
	op_t  push_op;
	logic q_full;
	logic q_empty;
	logic q_pop;
	op_t  q_head;
	logic last_take;
	logic clear_beat;
	logic lookup_beat;

	hklc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	hklc_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	hklc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Beat classes watched by the checks below
	assign last_take   = s_tvalid && s_tready && s_tlast && (s_tuser == CMD_BYTE);
	assign clear_beat  = m_tvalid && (m_tuser == KIND_CLEAR);
	assign lookup_beat = m_tvalid && (m_tuser == KIND_LOOKUP);

	// Back end never pops an empty queue
	`HKLC_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")

	// A last byte always leaves an operation queued
	`HKLC_ASSERT_NEXT(a_last_queued, clk, arst_n, last_take, !q_empty, "last byte not queued")

	// Clear answers carry an all-zero payload
	`HKLC_ASSERT_IMPL(a_clear_zero, clk, arst_n, clear_beat, m_tdata == '0, "clear result not zero")

	// Lookup-only answers never report an eviction
	`HKLC_ASSERT_IMPL(a_lookup_norepl, clk, arst_n, lookup_beat, !m_tdata[71], "eviction on lookup")

endmodule

`default_nettype wire
